// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// property wrappers for the checker file luva_checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define LUVA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("luva assertion failed");

// expression must never be true outside reset
`define LUVA_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("luva forbidden condition seen");

`endif

// ----- sv/luva_pkg.sv -----
// ----------------------------------------------------------------------------
// luva_pkg
// types, codes and default sizes of the least-used vector allocator
// ----------------------------------------------------------------------------
package luva_pkg;

  localparam int unsigned LUVA_VECTOR_BASE = 32;
  localparam int unsigned LUVA_NUM_VECTORS = 222;
  localparam int unsigned LUVA_COUNT_WIDTH = 8;

  localparam int unsigned VEC_W  = 8;
  localparam int unsigned STAT_W = 2;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } luva_func_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_ALLOCATED = 2'd0,
    STAT_FREED     = 2'd1,
    STAT_IGNORED   = 2'd2
  } luva_status_e;

  // strobes of the count store
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } luva_mem_ctl_t;

endpackage

// ----- sv/luva_cnt_store.sv -----
// ----------------------------------------------------------------------------
// luva_cnt_store
// usage count memory, one read and one write port, registered read
// ----------------------------------------------------------------------------
module luva_cnt_store #(
  parameter int unsigned NUM_VECTORS = luva_pkg::LUVA_NUM_VECTORS,
  parameter int unsigned COUNT_WIDTH = luva_pkg::LUVA_COUNT_WIDTH,
  parameter int unsigned IDX_W       = (NUM_VECTORS > 1) ? $clog2(NUM_VECTORS) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  luva_pkg::luva_mem_ctl_t ctl_i,
  input  logic [IDX_W-1:0]        rd_addr_i,
  input  logic [IDX_W-1:0]        wr_addr_i,
  input  logic [COUNT_WIDTH-1:0]  wr_cnt_i,
  output logic [COUNT_WIDTH-1:0]  rd_cnt_o
);
  import luva_pkg::*;

  logic [COUNT_WIDTH-1:0] mem_q [NUM_VECTORS];
  logic [NUM_VECTORS-1:0] vld_q;
  logic [COUNT_WIDTH-1:0] rd_data_q;
  logic                   rd_vld_q;

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ctl_i.wr_en) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_cnt_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
      rd_vld_q  <= vld_q[rd_addr_i];
    end
  end

  assign rd_cnt_o = rd_vld_q ? rd_data_q : '0;

endmodule

// ----- sv/least_used_vector_allocator.sv -----
// ----------------------------------------------------------------------------
// least_used_vector_allocator
// hands out the least used interrupt vector and takes back freed ones
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. An allocate
// request walks the usage counts one entry per clock through the single
// read port of the count memory in ST_SCAN, then writes the raised count
// in ST_ALLOC_WR, from which its result strobe done_o is registered;
// a free request needs one memory read and registers its result from
// ST_FREE_CHK. busy stays high until the result cycle, and a new request
// may be given in that very cycle. Results are shown for one cycle only
// and cannot be held off. The usage counts come out of reset as zero
// through per-entry valid flags, so the block is ready straight after reset.
// ----------------------------------------------------------------------------
module least_used_vector_allocator #(
  parameter int unsigned NUM_VECTORS = luva_pkg::LUVA_NUM_VECTORS,
  parameter int unsigned COUNT_WIDTH = luva_pkg::LUVA_COUNT_WIDTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        func_i,
  input  logic [luva_pkg::VEC_W-1:0]  vector_i,
  output logic                        done_o,
  output logic [luva_pkg::VEC_W-1:0]  result_vector_o,
  output logic [luva_pkg::STAT_W-1:0] status_o
);
  import luva_pkg::*;

  localparam int unsigned IDX_W = (NUM_VECTORS > 1) ? $clog2(NUM_VECTORS) : 1;
  localparam int unsigned ISS_W = $clog2(NUM_VECTORS + 1);

  // sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE     = 4'b0001,
    ST_SCAN     = 4'b0010,
    ST_ALLOC_WR = 4'b0100,
    ST_FREE_CHK = 4'b1000
  } state_e;

  // next index in circular order
  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
    wrap_inc = (idx == IDX_W'(NUM_VECTORS - 1)) ? '0 : idx + 1'b1;
  endfunction

  state_e state_q, state_d;

  logic [IDX_W-1:0]       nstart_q, nstart_d;   // rotating start of the scan
  logic [ISS_W-1:0]       iss_q, iss_d;         // reads issued so far
  logic [IDX_W-1:0]       addr_q, addr_d;       // next read address, or free target
  logic [IDX_W-1:0]       data_idx_q, data_idx_d;
  logic                   first_q, first_d;
  logic [IDX_W-1:0]       best_idx_q, best_idx_d;
  logic [COUNT_WIDTH-1:0] best_cnt_q, best_cnt_d;
  logic                   in_range_q, in_range_d;
  logic [VEC_W-1:0]       vector_q, vector_d;

  logic                   done_q, done_d;
  logic [VEC_W-1:0]       res_vec_q, res_vec_d;
  luva_status_e           status_q, status_d;

  luva_mem_ctl_t          mem_ctl;
  logic [IDX_W-1:0]       rd_addr, wr_addr, start_idx;
  logic [COUNT_WIDTH-1:0] wr_cnt, rd_cnt;

  logic [VEC_W:0]         free_diff;
  logic                   free_ok;

  // start index falls back to zero if ever out of range
  assign start_idx = ({1'b0, nstart_q} < (IDX_W + 1)'(NUM_VECTORS)) ? nstart_q : '0;

  // free range check: base <= vector < base + count
  assign free_diff = {1'b0, vector_i} - (VEC_W + 1)'(LUVA_VECTOR_BASE);
  assign free_ok   = !free_diff[VEC_W] &&
                     ({1'b0, free_diff[VEC_W-1:0]} < (VEC_W + 1)'(NUM_VECTORS));

  always_comb begin
    state_d    = state_q;
    nstart_d   = nstart_q;
    iss_d      = iss_q;
    addr_d     = addr_q;
    data_idx_d = data_idx_q;
    first_d    = first_q;
    best_idx_d = best_idx_q;
    best_cnt_d = best_cnt_q;
    in_range_d = in_range_q;
    vector_d   = vector_q;
    done_d     = 1'b0;
    res_vec_d  = res_vec_q;
    status_d   = status_q;
    mem_ctl    = '0;
    rd_addr    = addr_q;
    wr_addr    = addr_q;
    wr_cnt     = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          vector_d = vector_i;
          if (luva_func_e'(func_i) == FUNC_FREE) begin
            // single read of the named entry, skipped when out of range
            in_range_d    = free_ok;
            addr_d        = free_diff[IDX_W-1:0];
            rd_addr       = free_diff[IDX_W-1:0];
            mem_ctl.rd_en = free_ok;
            state_d       = ST_FREE_CHK;
          end else begin
            mem_ctl.rd_en = 1'b1;
            rd_addr       = start_idx;
            data_idx_d    = start_idx;
            addr_d        = wrap_inc(start_idx);
            iss_d         = ISS_W'(1);
            first_d       = 1'b1;
            state_d       = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // strict less keeps the earliest entry on a tie
        first_d = 1'b0;
        if (first_q || (rd_cnt < best_cnt_q)) begin
          best_cnt_d = rd_cnt;
          best_idx_d = data_idx_q;
        end
        if (iss_q == ISS_W'(NUM_VECTORS)) begin
          state_d = ST_ALLOC_WR;
        end else begin
          mem_ctl.rd_en = 1'b1;
          rd_addr       = addr_q;
          data_idx_d    = addr_q;
          addr_d        = wrap_inc(addr_q);
          iss_d         = iss_q + 1'b1;
        end
      end

      ST_ALLOC_WR: begin
        // count saturates at all ones
        mem_ctl.wr_en = 1'b1;
        wr_addr       = best_idx_q;
        wr_cnt        = (&best_cnt_q) ? best_cnt_q : best_cnt_q + 1'b1;
        nstart_d      = wrap_inc(best_idx_q);
        res_vec_d     = VEC_W'(LUVA_VECTOR_BASE) + VEC_W'(best_idx_q);
        status_d      = STAT_ALLOCATED;
        done_d        = 1'b1;
        state_d       = ST_IDLE;
      end

      ST_FREE_CHK: begin
        res_vec_d = vector_q;
        if (in_range_q && (rd_cnt != '0)) begin
          mem_ctl.wr_en = 1'b1;
          wr_addr       = addr_q;
          wr_cnt        = rd_cnt - 1'b1;
          status_d      = STAT_FREED;
        end else begin
          status_d      = STAT_IGNORED;
        end
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      nstart_q <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      nstart_q <= nstart_d;
      done_q   <= done_d;
    end
  end

  // working registers and result payload
  always_ff @(posedge clk_i) begin
    iss_q      <= iss_d;
    addr_q     <= addr_d;
    data_idx_q <= data_idx_d;
    first_q    <= first_d;
    best_idx_q <= best_idx_d;
    best_cnt_q <= best_cnt_d;
    in_range_q <= in_range_d;
    vector_q   <= vector_d;
    res_vec_q  <= res_vec_d;
    status_q   <= status_d;
  end

  luva_cnt_store #(
    .NUM_VECTORS (NUM_VECTORS),
    .COUNT_WIDTH (COUNT_WIDTH),
    .IDX_W       (IDX_W)
  ) u_cnt_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mem_ctl),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .wr_cnt_i  (wr_cnt),
    .rd_cnt_o  (rd_cnt)
  );

  assign busy            = (state_q != ST_IDLE);
  assign done_o          = done_q;
  assign result_vector_o = res_vec_q;
  assign status_o        = status_q;

endmodule

// ----- sv/luva_checker.sv -----
// ----------------------------------------------------------------------------
// luva_checker
// port-level checks of the allocator handshake and result timing
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module luva_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        done_o,
  input logic [luva_pkg::STAT_W-1:0] status_o
);
  import luva_pkg::*;

  // a result is only shown once the sequencer is free again
  `LUVA_ASSERT(a_done_not_busy, clk_i, rst_ni, done_o |-> !busy)
  // a taken request always occupies the sequencer
  `LUVA_ASSERT(a_accept_busy, clk_i, rst_ni, (start && !busy) |=> busy)
  // finishing a request always comes with its result
  `LUVA_ASSERT(a_fall_done, clk_i, rst_ni, $fell(busy) |-> done_o)
  // never two results from back-to-back cycles
  `LUVA_ASSERT_NEVER(a_done_twice, clk_i, rst_ni, done_o && $past(done_o))
  // a shown result carries one of the defined status codes
  `LUVA_ASSERT_NEVER(a_status_code, clk_i, rst_ni, done_o && (status_o > STAT_IGNORED))

endmodule

bind least_used_vector_allocator luva_checker u_luva_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .status_o (status_o)
);
